### design/mde_pkg.sv
// Package with constants, types and helpers of the dilate/erode morphology block.
`default_nettype none

package mde_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_KERNEL   = 5;
  localparam int MAX_CHANNELS = 4;
  localparam int ROWS_KEPT    = MAX_KERNEL - 1;
  localparam int XW           = $clog2(MAX_WIDTH);
  localparam int DW           = XW + 2;
  localparam int AW           = 5;
  localparam int OUT_DEPTH    = 4;
  localparam int PW           = $clog2(OUT_DEPTH);

  typedef logic [7:0] pix_t;
  typedef pix_t [MAX_CHANNELS-1:0] pixvec_t;
  typedef pixvec_t [MAX_KERNEL-1:0] col_t;
  typedef pixvec_t [ROWS_KEPT-1:0] lbword_t;

  typedef struct packed {
    pixvec_t res;
    logic    fe;
  } result_t;

  typedef enum logic [2:0] {
    REG_OP_MODE  = 3'd0,
    REG_KERNEL   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_BORDER   = 3'd5
  } reg_idx_e;

  function automatic pix_t pick(pix_t a, pix_t b, logic erode);
    if (erode) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### design/mde_in_if.sv
// Input pixel stream interface of the morphology block.
`default_nettype none

interface mde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_ch0;
  logic [7:0] pixel_ch1;
  logic [7:0] pixel_ch2;
  logic [7:0] pixel_ch3;
  logic       drain;

  modport source(output valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, drain,
                 input ready);
  modport sink(input valid, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3, drain,
               output ready);
endinterface

`default_nettype wire

### design/mde_out_if.sv
// Result stream interface of the morphology block.
`default_nettype none

interface mde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_ch0;
  logic [7:0] result_ch1;
  logic [7:0] result_ch2;
  logic [7:0] result_ch3;
  logic       frame_end;

  modport source(output valid, result_ch0, result_ch1, result_ch2, result_ch3, frame_end,
                 input ready);
  modport sink(input valid, result_ch0, result_ch1, result_ch2, result_ch3, frame_end,
               output ready);
endinterface

`default_nettype wire

### design/morph_dilate_erode_u8_core.sv
// Top level of the streaming 3x3/5x5 8-bit multi-channel dilate/erode block.
// Throughput: one beat per cycle while in_if.ready is high; input stalls during catch-up
// and when the result queue has no room for the results in flight.
// A frame shorter than its window lag pauses input after its last pixel while the
// window catches up. Reset is asynchronous and active low; it clears control state,
// the configuration registers and the queue pointers; the line memory is not cleared.
`default_nettype none

module morph_dilate_erode_u8_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mde_in_if.sink               in_if,
  mde_out_if.source            out_if,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire [mde_pkg::AW-1:0] paddr,
  input  wire [31:0]           pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mde_pkg::*;

  logic        op_q, ksel_q;
  logic [2:0]  chcnt_q;
  logic [11:0] width_q;
  logic [15:0] height_q;
  logic [7:0]  border_q;
  logic        cfg_we;

  logic [11:0] eff_w;
  logic [15:0] eff_h;
  logic [2:0]  eff_ch;
  logic [DW-1:0] delay;

  logic [XW-1:0] xq_q, ox_q;
  logic [16:0]   yq_q;
  logic [15:0]   oy_q;
  logic [DW-1:0] lag_q;

  logic all_in, lag_done, adv, in_acc, step, emit, last;
  logic [2:0] pend;

  logic [MAX_KERNEL-1:0] ker_m, colok_m, rowok_m;

  logic          s1_v_q, s1_e_q, s1_fe_q;
  logic [XW-1:0] s1_x_q;
  pixvec_t       s1_pix_q;
  logic [MAX_KERNEL-1:0] s1_ker_q, s1_col_q, s1_row_q;

  logic          s2_v_q, s2_fe_q;
  logic [MAX_KERNEL-1:0] s2_ker_q, s2_col_q, s2_row_q;

  lbword_t line_mem [MAX_WIDTH];
  lbword_t rd_q, byp_data_q, rd_word;
  logic    byp_q;
  col_t    col;
  col_t    cw_q [MAX_KERNEL];

  pix_t    val [MAX_KERNEL][MAX_KERNEL];
  pix_t    colred [MAX_KERNEL];
  pixvec_t res;
  pix_t    ident;

  result_t fifo_q [OUT_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [2:0]    cnt_q;
  logic          pop;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= 1'b0;
      ksel_q   <= 1'b0;
      chcnt_q  <= 3'd1;
      width_q  <= 12'(MAX_WIDTH);
      height_q <= 16'd1;
      border_q <= 8'd0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[AW-1:2]))
        REG_OP_MODE:  op_q     <= pwdata[0];
        REG_KERNEL:   ksel_q   <= pwdata[0];
        REG_CHANNELS: chcnt_q  <= pwdata[2:0];
        REG_WIDTH:    width_q  <= pwdata[11:0];
        REG_HEIGHT:   height_q <= pwdata[15:0];
        REG_BORDER:   border_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[AW-1:2]))
      REG_OP_MODE:  prdata = {31'd0, op_q};
      REG_KERNEL:   prdata = {31'd0, ksel_q};
      REG_CHANNELS: prdata = {29'd0, chcnt_q};
      REG_WIDTH:    prdata = {20'd0, width_q};
      REG_HEIGHT:   prdata = {16'd0, height_q};
      REG_BORDER:   prdata = {24'd0, border_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Effective configuration.
  always_comb begin
    eff_w = width_q;
    if (width_q == 12'd0) eff_w = 12'd1;
    if (width_q > 12'(MAX_WIDTH)) eff_w = 12'(MAX_WIDTH);
    eff_h  = (height_q == 16'd0) ? 16'd1 : height_q;
    eff_ch = chcnt_q;
    if (chcnt_q == 3'd0) eff_ch = 3'd1;
    if (chcnt_q > 3'(MAX_CHANNELS)) eff_ch = 3'(MAX_CHANNELS);
    delay = ksel_q ? ({eff_w, 1'b0} + DW'(2)) : ({1'b0, eff_w} + DW'(1));
  end

  // Input side sequencing.
  assign all_in   = yq_q >= {1'b0, eff_h};
  assign lag_done = lag_q >= delay;
  assign adv      = all_in && !lag_done;
  assign pend     = cnt_q + {2'd0, s1_v_q & s1_e_q} + {2'd0, s2_v_q};
  assign in_if.ready = !adv && (pend <= 3'(OUT_DEPTH - 1));
  assign in_acc   = in_if.valid && in_if.ready;
  assign step     = adv || (in_acc && (all_in || !in_if.drain));
  assign emit     = step && lag_done;
  assign last     = ({1'b0, ox_q} == eff_w - 12'd1) && (oy_q == eff_h - 16'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xq_q  <= '0;
      yq_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      lag_q <= '0;
    end else if (cfg_we || (emit && last)) begin
      xq_q  <= '0;
      yq_q  <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
      lag_q <= '0;
    end else begin
      if (step) begin
        if (!lag_done) lag_q <= lag_q + DW'(1);
        if ({1'b0, xq_q} == eff_w - 12'd1) begin
          xq_q <= '0;
          yq_q <= yq_q + 17'd1;
        end else begin
          xq_q <= xq_q + XW'(1);
        end
      end
      if (emit) begin
        if ({1'b0, ox_q} == eff_w - 12'd1) begin
          ox_q <= '0;
          oy_q <= oy_q + 16'd1;
        end else begin
          ox_q <= ox_q + XW'(1);
        end
      end
    end
  end

  // Window masks for the result position.
  always_comb begin
    int d;
    logic signed [12:0] sx;
    logic signed [17:0] sy;
    for (int e = 0; e < MAX_KERNEL; e++) begin
      d  = e - 2 - (ksel_q ? 0 : 1);
      sx = $signed({2'b00, ox_q}) + 13'(d);
      sy = $signed({2'b00, oy_q}) + 18'(d);
      ker_m[e]   = ksel_q ? (d >= -2 && d <= 2) : (d >= -1 && d <= 1);
      colok_m[e] = (sx >= 0) && (sx < $signed({1'b0, eff_w}));
      rowok_m[e] = (sy >= 0) && (sy < $signed({2'b00, eff_h}));
    end
  end

  // Stage 1: line memory read in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_e_q <= 1'b0;
      s2_v_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      s1_v_q <= step;
      s1_e_q <= emit;
      s2_v_q <= s1_v_q & s1_e_q;
      byp_q  <= s1_v_q && (s1_x_q == xq_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q   <= xq_q;
    s1_pix_q <= {in_if.pixel_ch3, in_if.pixel_ch2, in_if.pixel_ch1, in_if.pixel_ch0};
    s1_fe_q  <= last;
    s1_ker_q <= ker_m;
    s1_col_q <= colok_m;
    s1_row_q <= rowok_m;
    s2_fe_q  <= s1_fe_q;
    s2_ker_q <= s1_ker_q;
    s2_col_q <= s1_col_q;
    s2_row_q <= s1_row_q;
  end

  always_comb begin
    rd_word = byp_q ? byp_data_q : rd_q;
    for (int j = 0; j < ROWS_KEPT; j++) begin
      col[j] = rd_word[j];
    end
    col[MAX_KERNEL-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      line_mem[s1_x_q] <= col[MAX_KERNEL-1:1];
    end
    rd_q       <= line_mem[xq_q];
    byp_data_q <= col[MAX_KERNEL-1:1];
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int e = 0; e < MAX_KERNEL - 1; e++) begin
        cw_q[e] <= cw_q[e+1];
      end
      cw_q[MAX_KERNEL-1] <= col;
    end
  end

  // Stage 2: window reduction.
  assign ident = op_q ? 8'hFF : 8'h00;

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      for (int ec = 0; ec < MAX_KERNEL; ec++) begin
        for (int er = 0; er < MAX_KERNEL; er++) begin
          if (!(s2_ker_q[ec] && s2_ker_q[er])) begin
            val[ec][er] = ident;
          end else if (!(s2_col_q[ec] && s2_row_q[er])) begin
            val[ec][er] = border_q;
          end else begin
            val[ec][er] = cw_q[ec][er][c];
          end
        end
        colred[ec] = pick(pick(pick(val[ec][0], val[ec][1], op_q),
                               pick(val[ec][2], val[ec][3], op_q), op_q),
                          val[ec][4], op_q);
      end
      res[c] = pick(pick(pick(colred[0], colred[1], op_q),
                         pick(colred[2], colred[3], op_q), op_q),
                    colred[4], op_q);
      if (3'(c) >= eff_ch) res[c] = 8'd0;
    end
  end

  // Result queue.
  assign pop          = out_if.valid && out_if.ready;
  assign out_if.valid = cnt_q != 3'd0;
  assign out_if.result_ch0 = fifo_q[rptr_q].res[0];
  assign out_if.result_ch1 = fifo_q[rptr_q].res[1];
  assign out_if.result_ch2 = fifo_q[rptr_q].res[2];
  assign out_if.result_ch3 = fifo_q[rptr_q].res[3];
  assign out_if.frame_end  = fifo_q[rptr_q].fe;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      fifo_q[wptr_q] <= '{res: res, fe: s2_fe_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (s2_v_q) wptr_q <= wptr_q + PW'(1);
      if (pop) rptr_q <= rptr_q + PW'(1);
      cnt_q <= cnt_q + {2'd0, s2_v_q} - {2'd0, pop};
    end
  end

  property p_queue_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(OUT_DEPTH);
  endproperty
  a_queue_bound: assert property (p_queue_bound) else $error("result queue overflow");

  property p_push_room;
    @(posedge clk_i) disable iff (!rst_ni) s2_v_q |-> (cnt_q < 3'(OUT_DEPTH)) || pop;
  endproperty
  a_push_room: assert property (p_push_room) else $error("result pushed into full queue");

  property p_adv_stall;
    @(posedge clk_i) disable iff (!rst_ni) adv |-> !in_if.ready;
  endproperty
  a_adv_stall: assert property (p_adv_stall) else $error("input taken during catch-up");

  property p_emit_step;
    @(posedge clk_i) disable iff (!rst_ni) s1_e_q |-> s1_v_q;
  endproperty
  a_emit_step: assert property (p_emit_step) else $error("result without window step");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench of the streaming dilate/erode morphology block.
`default_nettype none

module tb;
  import mde_pkg::*;

  localparam int NUM_REGS = 6;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  mde_in_if in_bus();
  mde_out_if out_bus();

  morph_dilate_erode_u8_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_bus.sink), .out_if(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic        cfg_erode;
  logic        cfg_kernel;
  logic [2:0]  cfg_chan;
  logic [11:0] cfg_width;
  logic [15:0] cfg_height;
  logic [7:0]  cfg_border;

  pixvec_t  line_mem [8][MAX_WIDTH];
  int       next_col, next_row, sent_results;
  bit       frame_done;
  result_t  expected_q[$];
  int       errors;
  int       burst_left;
  int       gap_max;
  int       ready_pct;
  int       idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height == 0) ? 1 : int'(cfg_height);
  endfunction

  function automatic int eff_chan();
    if (cfg_chan == 0) return 1;
    if (cfg_chan > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(cfg_chan);
  endfunction

  function automatic int win_radius();
    return (cfg_kernel && MAX_KERNEL >= 5) ? 2 : 1;
  endfunction

  function automatic pixvec_t window_extreme(int k);
    pixvec_t res;
    int w, h, r, oy, ox, y, x;
    pix_t acc, v;
    w = eff_width();
    h = eff_height();
    r = win_radius();
    oy = k / w;
    ox = k % w;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      acc = cfg_erode ? 8'hFF : 8'h00;
      for (int dy = -r; dy <= r; dy++) begin
        for (int dx = -r; dx <= r; dx++) begin
          y = oy + dy;
          x = ox + dx;
          if (y < 0 || y >= h || x < 0 || x >= w) v = cfg_border;
          else v = line_mem[y % 8][x][c];
          if (cfg_erode) begin
            if (v < acc) acc = v;
          end else begin
            if (v > acc) acc = v;
          end
        end
      end
      res[c] = (c < eff_chan()) ? acc : 8'h00;
    end
    return res;
  endfunction

  task automatic predict_beat(input pixvec_t px, input logic drain);
    int w, h, r, p;
    result_t exp_res;
    w = eff_width();
    h = eff_height();
    r = win_radius();
    if (next_row < h && !drain) begin
      p = next_row * w + next_col;
      line_mem[next_row % 8][next_col] = px;
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
      if (p < r * w + r) return;
    end else if (next_row < h) begin
      return;
    end
    exp_res.res = window_extreme(sent_results);
    sent_results++;
    exp_res.fe = (sent_results >= w * h);
    if (exp_res.fe) begin
      next_col = 0;
      next_row = 0;
      sent_results = 0;
      frame_done = 1'b1;
    end
    expected_q.push_back(exp_res);
  endtask

  function automatic pixvec_t rand_pixel();
    pixvec_t px;
    for (int c = 0; c < MAX_CHANNELS; c++) px[c] = 8'($urandom);
    return px;
  endfunction

  task automatic send_beat(input pixvec_t px, input logic drain);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_bus.valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_bus.valid = 1'b1;
    {in_bus.pixel_ch3, in_bus.pixel_ch2, in_bus.pixel_ch1, in_bus.pixel_ch0} = px;
    in_bus.drain = drain;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_beat(px, drain);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_bus.valid = 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (2 * eff_width() + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    wait_idle();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = AW'(idx * 4);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_OP_MODE:  cfg_erode = value[0];
      REG_KERNEL:   cfg_kernel = value[0];
      REG_CHANNELS: cfg_chan = value[2:0];
      REG_WIDTH:    cfg_width = value[11:0];
      REG_HEIGHT:   cfg_height = value[15:0];
      REG_BORDER:   cfg_border = value[7:0];
      default: ;
    endcase
    next_col = 0;
    next_row = 0;
    sent_results = 0;
  endtask

  task automatic set_config(input logic erode, input logic kern, input logic [2:0] chan,
                            input logic [11:0] w, input logic [15:0] h,
                            input logic [7:0] border);
    write_reg(REG_OP_MODE, 32'(erode));
    write_reg(REG_KERNEL, 32'(kern));
    write_reg(REG_CHANNELS, 32'(chan));
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    write_reg(REG_BORDER, 32'(border));
  endtask

  // Sends one frame; stop_at below the pixel count abandons the frame there.
  task automatic send_frame(input int drain_pct, input int stop_at, input bit fixed_px,
                            input pixvec_t px_val);
    int n;
    n = eff_width() * eff_height();
    frame_done = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i == stop_at) return;
      if ($urandom_range(0, 99) < drain_pct) send_beat(rand_pixel(), 1'b1);
      send_beat(fixed_px ? px_val : rand_pixel(), 1'b0);
    end
    while (!frame_done) send_beat(rand_pixel(), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_tiny_frames();
    for (int m = 0; m < 4; m++) begin
      set_config(m[0], m[1], 3'd4, 12'd1, 16'd1, m[0] ? 8'hFF : 8'h00);
      send_frame(0, 1 << 30, 1'b1, m[0] ? '0 : '1);
    end
    set_config(1'b0, 1'b1, 3'd3, 12'd3, 16'd2, 8'h80);
    send_frame(50, 1 << 30, 1'b0, '0);
    set_config(1'b1, 1'b0, 3'd0, 12'd0, 16'd0, 8'h7F);
    send_frame(0, 1 << 30, 1'b1, '1);
    set_config(1'b0, 1'b0, 3'd7, 12'd2, 16'd2, 8'h01);
    send_frame(30, 1 << 30, 1'b0, '0);
    write_reg(NUM_REGS, 32'hFFFF_FFFF);
    send_frame(0, 1 << 30, 1'b0, '0);
  endtask

  task automatic test_wide_rows();
    set_config(1'b1, 1'b1, 3'd5, 12'd64, 16'd2, 8'hFF);
    send_frame(0, 1 << 30, 1'b0, '0);
  endtask

  task automatic test_drained_pause();
    set_config(1'b1, 1'b0, 3'd3, 12'd6, 16'd5, 8'h40);
    send_frame(0, 20, 1'b0, '0);
    in_bus.valid = 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    for (int i = 0; i < 10; i++) send_beat(rand_pixel(), 1'b0);
    frame_done = 1'b0;
    while (!frame_done) send_beat(rand_pixel(), 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 350) begin
      ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 3'($urandom_range(0, 7)), 12'($urandom_range(0, 12)),
                 16'($urandom_range(0, 8)), 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_frame(10, $urandom_range(0, 20), 1'b0, '0);
      else send_frame($urandom_range(0, 1) ? 0 : 10, 1 << 30, 1'b0, '0);
      sent += eff_width() * eff_height();
    end
  endtask

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_bus.result_ch0 !== exp_res.res[0]) begin
          $error("result_ch0 expected %0d actual %0d", exp_res.res[0], out_bus.result_ch0);
          errors++;
        end
        if (out_bus.result_ch1 !== exp_res.res[1]) begin
          $error("result_ch1 expected %0d actual %0d", exp_res.res[1], out_bus.result_ch1);
          errors++;
        end
        if (out_bus.result_ch2 !== exp_res.res[2]) begin
          $error("result_ch2 expected %0d actual %0d", exp_res.res[2], out_bus.result_ch2);
          errors++;
        end
        if (out_bus.result_ch3 !== exp_res.res[3]) begin
          $error("result_ch3 expected %0d actual %0d", exp_res.res[3], out_bus.result_ch3);
          errors++;
        end
        if (out_bus.frame_end !== exp_res.fe) begin
          $error("frame_end expected %0d actual %0d", exp_res.fe, out_bus.frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.pixel_ch0 = '0;
    in_bus.pixel_ch1 = '0;
    in_bus.pixel_ch2 = '0;
    in_bus.pixel_ch3 = '0;
    in_bus.drain = 1'b0;
    out_bus.ready = 1'b0;
    idle_cycles = 0;
    errors = 0;
    burst_left = 0;
    gap_max = 4;
    ready_pct = 70;
    cfg_erode = 1'b0;
    cfg_kernel = 1'b0;
    cfg_chan = 3'd1;
    cfg_width = 12'd2048;
    cfg_height = 16'd1;
    cfg_border = 8'd0;
    next_col = 0;
    next_row = 0;
    sent_results = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_tiny_frames();
    test_wide_rows();
    test_drained_pause();
    test_random_frames();
    in_bus.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
